/* rtl/core/smpf_pkg.sv */
`default_nettype none

package smpf_pkg;

  // receive fifo sizing
  localparam int FIFO_DEPTH = 16;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int ID_COUNT   = 6;

  // operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_MOUSE = 2'd2;

  // register offsets with special behavior
  localparam logic [2:0] PORT_DATA   = 3'd0;
  localparam logic [2:0] PORT_MCR    = 3'd4;
  localparam logic [2:0] PORT_STATUS = 3'd5;

  // byte constants
  localparam logic [7:0] ID_BYTE     = 8'h4D;
  localparam logic [7:0] STATUS_IDLE = 8'h01;
  localparam logic [7:0] STATUS_DATA = 8'h60;
  localparam logic [1:0] SYNC_BITS   = 2'b11;

  typedef struct packed {
    logic [1:0]        operation;
    logic [2:0]        port;
    logic [7:0]        write_data;
    logic              left_button;
    logic              right_button;
    logic signed [7:0] x_move;
    logic signed [7:0] y_move;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_pulse;
  } out_result_t;

  // commands from the port logic to the fifo
  typedef struct packed {
    logic       pop;
    logic       id_reset;
    logic       push3;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
  } fifo_cmd_t;

  // fifo status seen by the port logic
  typedef struct packed {
    logic [7:0] head;
    logic       nonempty;
    logic       multi;
  } fifo_stat_t;

endpackage

`default_nettype wire

/* rtl/core/smpf_in_stage.sv */
`default_nettype none

module smpf_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire smpf_pkg::in_item_t in_item,
  output logic                   item_valid,
  output smpf_pkg::in_item_t     item
);

  logic               valid_r;
  smpf_pkg::in_item_t item_r;

  // valid flag for the captured item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  // capture the payload on each transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

/* rtl/core/smpf_rx_fifo.sv */
`default_nettype none

module smpf_rx_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire smpf_pkg::fifo_cmd_t cmd,
  output smpf_pkg::fifo_stat_t     stat
);

  localparam int D = smpf_pkg::FIFO_DEPTH;
  localparam int W = smpf_pkg::CNT_W;

  logic [7:0]   entry_r   [D];
  logic [7:0]   entry_nxt [D];
  logic [W-1:0] count_r;
  logic [W-1:0] count_nxt;
  logic [W:0]   count_ext;
  logic [W:0]   sum3;

  assign count_ext = {1'b0, count_r};
  assign sum3      = count_ext + (W+1)'(3);

  // per-entry next value: shift on pop, ID bytes on id reset, fill on push
  for (genvar i = 0; i < D; i++) begin : g_entry
    localparam logic [W:0] IDX = (W+1)'(i);
    always_comb begin
      entry_nxt[i] = entry_r[i];
      if (cmd.pop) begin
        if (i < D - 1) begin
          entry_nxt[i] = entry_r[(i < D - 1) ? i + 1 : i];
        end
      end else if (cmd.id_reset) begin
        if (i < smpf_pkg::ID_COUNT) begin
          entry_nxt[i] = smpf_pkg::ID_BYTE;
        end
      end else if (cmd.push3) begin
        if (IDX == count_ext) begin
          entry_nxt[i] = cmd.byte0;
        end else if (IDX == count_ext + (W+1)'(1)) begin
          entry_nxt[i] = cmd.byte1;
        end else if (IDX == count_ext + (W+1)'(2)) begin
          entry_nxt[i] = cmd.byte2;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        entry_r[i] <= 8'h00;
      end else begin
        entry_r[i] <= entry_nxt[i];
      end
    end
  end

  // fill count, saturating at the depth
  always_comb begin
    count_nxt = count_r;
    if (cmd.pop) begin
      if (count_r != '0) begin
        count_nxt = count_r - W'(1);
      end
    end else if (cmd.id_reset) begin
      count_nxt = W'(smpf_pkg::ID_COUNT);
    end else if (cmd.push3) begin
      if (sum3 > (W+1)'(D)) begin
        count_nxt = W'(D);
      end else begin
        count_nxt = sum3[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign stat.head     = entry_r[0];
  assign stat.nonempty = (count_r != '0);
  assign stat.multi    = (count_r > W'(1));

endmodule

`default_nettype wire

/* rtl/core/smpf_port_ctrl.sv */
`default_nettype none

module smpf_port_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 item_valid,
  input  wire smpf_pkg::in_item_t   item,
  input  wire smpf_pkg::fifo_stat_t stat,
  output smpf_pkg::fifo_cmd_t       cmd,
  output logic                      out_valid,
  output smpf_pkg::out_result_t     out_result
);

  logic [7:0]            regs_r   [8];
  logic [7:0]            regs_nxt [8];
  logic                  valid_r;
  smpf_pkg::out_result_t result_r;
  smpf_pkg::out_result_t result_nxt;
  logic                  is_read;
  logic                  is_write;
  logic                  is_mouse;
  logic                  id_change;

  assign is_read  = item_valid && (item.operation == smpf_pkg::OP_READ);
  assign is_write = item_valid && (item.operation == smpf_pkg::OP_WRITE);
  assign is_mouse = item_valid && (item.operation == smpf_pkg::OP_MOUSE);

  // mouse reset when bit 0 of the modem control register toggles
  assign id_change = is_write && (item.port == smpf_pkg::PORT_MCR) &&
                     (item.write_data[0] != regs_r[smpf_pkg::PORT_MCR][0]);

  // fifo commands, three-byte motion packet
  always_comb begin
    cmd.pop      = is_read && (item.port == smpf_pkg::PORT_DATA);
    cmd.id_reset = id_change;
    cmd.push3    = is_mouse;
    cmd.byte0    = {smpf_pkg::SYNC_BITS, item.left_button, item.right_button,
                    item.y_move[7:6], item.x_move[7:6]};
    cmd.byte1    = {2'b00, item.x_move[5:0]};
    cmd.byte2    = {2'b00, item.y_move[5:0]};
  end

  // register file update
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      regs_nxt[i] = regs_r[i];
    end
    if (is_write) begin
      regs_nxt[item.port] = item.write_data;
    end else if (cmd.pop) begin
      regs_nxt[smpf_pkg::PORT_MCR] = {7'b0, ~regs_r[smpf_pkg::PORT_MCR][0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        regs_r[i] <= 8'h00;
      end
    end else begin
      for (int i = 0; i < 8; i++) begin
        regs_r[i] <= regs_nxt[i];
      end
    end
  end

  // result data and interrupt
  always_comb begin
    result_nxt.read_data = 8'h00;
    result_nxt.irq_pulse = 1'b0;
    if (is_read) begin
      case (item.port)
        smpf_pkg::PORT_DATA: begin
          result_nxt.read_data = stat.head;
          result_nxt.irq_pulse = stat.multi;
        end
        smpf_pkg::PORT_STATUS: begin
          result_nxt.read_data = stat.nonempty ?
                                 (smpf_pkg::STATUS_DATA | smpf_pkg::STATUS_IDLE) :
                                 smpf_pkg::STATUS_IDLE;
        end
        default: begin
          result_nxt.read_data = regs_r[item.port];
        end
      endcase
    end else if (id_change) begin
      result_nxt.irq_pulse = 1'b1;
    end else if (is_mouse) begin
      result_nxt.irq_pulse = !stat.nonempty;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

`default_nettype wire

/* rtl/core/serial_mouse_port_fifo_core.sv */
// Serial mouse port: eight byte registers with a 16-byte receive fifo.
// Input channel: drive in_item with start high; the item is taken at a rising
// edge where start is high and busy is low. busy stays low, so an item may be
// given in every cycle.
// Operations: port read, port write, mouse event (three-byte packet push).
// Toggling bit 0 of register 4 empties the fifo and queues six 'M' bytes;
// reading register 0 pops the head byte.
// Result channel: one result per item, on out_result for exactly one cycle
// with out_valid high; the item passes the input register, then the state
// update and result register.
// Throughput: one item per cycle; the fifo is a shift register whose
// entries all update in the same cycle, so no item waits on another.
// Reset: synchronous active-low rst_n clears the fifo bytes, the fill count
// and the register file to zero and drops any item in flight.
// The receiver cannot stall; a result not taken in its cycle is gone.
`default_nettype none

module serial_mouse_port_fifo_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire smpf_pkg::in_item_t    in_item,
  output logic                       out_valid,
  output smpf_pkg::out_result_t      out_result
);

  logic                 accept;
  logic                 item_valid;
  smpf_pkg::in_item_t   item;
  smpf_pkg::fifo_cmd_t  cmd;
  smpf_pkg::fifo_stat_t stat;

  // never holds off the sender
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // input register
  smpf_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item)
  );

  // receive fifo
  smpf_rx_fifo u_rx_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  // register file, decode and result register
  smpf_port_ctrl u_port_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .stat       (stat),
    .cmd        (cmd),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

`default_nettype wire
